### design/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and codes for the varint stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsd_pkg;

  // Decode modes (the unused code decodes as a 32-bit varint)
  localparam logic [1:0] MODE_VARINT  = 2'd0;
  localparam logic [1:0] MODE_VARLONG = 2'd1;
  localparam logic [1:0] MODE_STRLEN  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_BAD_VALUE = 2'd3;

  // Register indexes on the APB port
  localparam logic REG_DECODE_MODE = 1'b0;
  localparam logic REG_CHAR_LIMIT  = 1'b1;

  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned CHAR_LIMIT_W = 29;
  localparam logic [CHAR_LIMIT_W-1:0] CHAR_LIMIT_RESET = 29'd32767;

  // Byte layout
  localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
  localparam int unsigned CONT_BIT    = 7;

  // Bytes allowed per item: 35 / 7 and 70 / 7
  localparam logic [3:0] VARINT_BYTES  = 4'(35 / 7);
  localparam logic [3:0] VARLONG_BYTES = 4'(70 / 7);

  typedef struct packed {
    logic [1:0]              decode_mode;
    logic [CHAR_LIMIT_W-1:0] char_limit;
  } cfg_t;

endpackage

### design/vsd_regs.sv
// ----------------------------------------------------------------------------
// vsd_regs
// APB configuration registers: decode mode and character limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsd_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vsd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output vsd_pkg::cfg_t              cfg_o
);
  import vsd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // Update the addressed register on the access beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DECODE_MODE: cfg_d.decode_mode = pwdata[1:0];
        REG_CHAR_LIMIT:  cfg_d.char_limit  = pwdata[CHAR_LIMIT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_mode <= MODE_VARINT;
      cfg_q.char_limit  <= CHAR_LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_DECODE_MODE: prdata = {30'd0, cfg_q.decode_mode};
      REG_CHAR_LIMIT:  prdata = {3'd0, cfg_q.char_limit};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### design/vsd_core.sv
// ----------------------------------------------------------------------------
// vsd_core
// Input register, one-byte varint step and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vsd_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               buffer_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] value_o,
  output logic [1:0]         status_o
);
  import vsd_pkg::*;

  // Input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Item state
  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;

  // Result stage
  logic              out_valid_q;
  logic signed [63:0] value_q;
  logic [1:0]        status_q;

  // Step logic
  logic        longform;
  logic [3:0]  limit;
  logic [6:0]  shift;
  logic [63:0] acc_or;
  logic [3:0]  cnt_next;
  logic [63:0] val_full;
  logic        cont;
  logic        too_big;
  logic        emit;
  logic [63:0] res_value;
  logic [1:0]  res_status;
  logic        out_free;
  logic        advance;
  logic        in_load;

  // Merge this byte's seven payload bits
  assign longform = (cfg_i.decode_mode == MODE_VARLONG);
  assign limit    = longform ? VARLONG_BYTES : VARINT_BYTES;
  assign shift    = {cnt_q, 3'b000} - {3'b000, cnt_q};
  assign acc_or   = (shift < 7'd64)
                  ? (acc_q | ({56'd0, in_byte_q & PAYLOAD_MASK} << shift[5:0]))
                  : acc_q;
  assign cnt_next = cnt_q + 4'd1;
  assign cont     = in_byte_q[CONT_BIT];

  // Sign-extend from bit 31 outside varlong mode
  assign val_full = longform ? acc_or : {{32{acc_or[31]}}, acc_or[31:0]};
  assign too_big  = (val_full[31:0] > {1'b0, cfg_i.char_limit, 2'b00});

  // Classify the byte
  always_comb begin
    res_value  = 64'd0;
    res_status = ST_OK;
    emit       = 1'b1;
    priority if (!cont) begin
      if ((cfg_i.decode_mode == MODE_STRLEN) && (val_full[63] || too_big)) begin
        res_status = ST_BAD_VALUE;
      end else begin
        res_value = val_full;
      end
    end else if (cnt_next >= limit) begin
      res_status = ST_OVERFLOW;
    end else if (in_end_q) begin
      res_status = ST_TRUNCATED;
    end else begin
      emit = 1'b0;
    end
  end

  // Handshake: advance unless a result has nowhere to go
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  // Next item state: restart after any result
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (advance) begin
      if (emit) begin
        acc_d = 64'd0;
        cnt_d = 4'd0;
      end else begin
        acc_d = acc_or;
        cnt_d = cnt_next;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 64'd0;
      cnt_q       <= 4'd0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture input beat, hold result until taken
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= buffer_end_i;
    end
    if (advance && emit) begin
      value_q  <= res_value;
      status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

### design/varint_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// varint_stream_decoder_top
// Byte-serial LEB128 decoder for 32-bit varints, 64-bit varlongs and
// range-checked string length prefixes.
//
//   Port group   Dir  Handshake                    Beat contents
//   in           in   in_valid_i / in_stall_o      data_byte_i, buffer_end_i
//   out          out  out_valid_o / out_stall_i    value_o, status_o
//   cfg (APB)    in   psel, penable, pready        paddr, pwdata / prdata
//
// One byte per cycle unless a stalled result blocks the next: a beat waits in
// the input register, the step logic (shift, OR, compare) resolves it and a
// result lands in the output register.
// Reset clears the partial item and loads mode 0 and a limit of 32767.
// A stalled result only holds back a byte that would make another result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module varint_stream_decoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vsd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Byte input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       buffer_end_i,
  // Result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [63:0]         value_o,
  output logic [1:0]                 status_o
);
  import vsd_pkg::*;

  cfg_t cfg;

  // Configuration registers
  vsd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Decode datapath
  vsd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .status_o     (status_o)
  );

endmodule
